@@ rtl/core/bsp_pkg.sv @@
// Shared constants, types and helpers for the box screen-bounds projector.
`default_nettype none
package bsp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QW        = 32;
   localparam int MAT_SIZE  = 16;
   localparam int CORNERS   = 8;
   localparam int CNT_W     = $clog2(CORNERS);
   localparam int QBITS     = FRAC_BITS + 1;
   localparam int NUMW      = QW + FRAC_BITS;
   localparam int WIDE      = 64;
   localparam int VP_W      = 16;
   localparam int SCALE_W   = 21;
   localparam int SCALE_SHIFT = 17;
   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(65536);
   localparam int CSR_IDX_W = 2;

   localparam logic signed [WIDE-1:0] Q_MAX_W = (WIDE'(64'sd1) <<< (QW - 1)) - WIDE'(64'sd1);
   localparam logic signed [WIDE-1:0] Q_MIN_W = -(WIDE'(64'sd1) <<< (QW - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VP_WIDTH     = 2'd0,
      CSR_VP_HEIGHT    = 2'd1,
      CSR_BOUNDS_SCALE = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_BOX  = 1'b1
   } mode_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

   typedef struct packed {
      logic             neg;
      logic [NUMW-1:0]  rem;
      logic [QBITS-1:0] quo;
   } div_lane_type;

   function automatic logic signed [QW-1:0] sat_q(input logic signed [WIDE-1:0] v);
      logic signed [QW-1:0] r;
      if (v > Q_MAX_W) begin
         r = Q_MAX_W[QW-1:0];
      end else if (v < Q_MIN_W) begin
         r = Q_MIN_W[QW-1:0];
      end else begin
         r = v[QW-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/box_screen_bounds_projector.sv @@
// Top level of the box screen-bounds projector: corner sequencer, matrix, pipeline, output.
`default_nettype none
// A load transaction (req_mode 0) writes one coefficient of the 4x4 matrix at once
// and returns nothing; a box transaction (req_mode 1) returns one bounds transaction.
// The corner sequencer issues the eight corners of a box one per cycle into the
// pipeline unless it is halted; no request is taken while corners issue, but the
// next box or load can be taken with the last corner. Most of a box's path lies in
// the one-bit-per-stage divider. Coefficients loaded while a box is still in flight
// do not affect it. The output register lets the pipeline keep running while a
// finished result waits on rsp_ready; it halts only when a second result is ready.
module box_screen_bounds_projector import bsp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic [3:0]            req_coef_index,
   input  wire logic signed [QW-1:0]  req_coef_value,
   input  wire logic signed [QW-1:0]  req_box_min_x,
   input  wire logic signed [QW-1:0]  req_box_min_y,
   input  wire logic signed [QW-1:0]  req_box_min_z,
   input  wire logic signed [QW-1:0]  req_box_max_x,
   input  wire logic signed [QW-1:0]  req_box_max_y,
   input  wire logic signed [QW-1:0]  req_box_max_z,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_on_screen,
   output logic signed [QW-1:0]       rsp_screen_min_x,
   output logic signed [QW-1:0]       rsp_screen_min_y,
   output logic signed [QW-1:0]       rsp_screen_max_x,
   output logic signed [QW-1:0]       rsp_screen_max_y,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SCALE_W-1:0]    csr_wdata
);

   logic signed [QW-1:0] mat_ff [MAT_SIZE];
   logic [VP_W-1:0]      vp_width_ff, vp_height_ff;
   logic [SCALE_W-1:0]   scale_ff;
   logic                 busy_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic signed [QW-1:0] lo_ff [3];
   logic signed [QW-1:0] hi_ff [3];
   logic signed [QW-1:0] vec [3];
   logic                 en, accept, last_corner;
   tag_type              seq_tag, clip_tag, div_tag;
   logic signed [QW-1:0] clip_x, clip_y, clip_w;
   logic                 div_ok;
   logic signed [QBITS:0] ndc_x, ndc_y;
   logic                 res_valid, res_on;
   logic signed [QW-1:0] res_min_x, res_min_y, res_max_x, res_max_y;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 on_ff;
   logic signed [QW-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   // The pipeline only halts when a finished result would meet a full output register.
   assign en          = rsp_ready || !rsp_valid_ff || !res_valid;
   assign last_corner = (cnt_ff == CNT_W'(CORNERS - 1));
   assign req_ready   = en && (!busy_ff || last_corner);
   assign accept      = req_valid && req_ready;

   assign vec[0] = cnt_ff[2] ? hi_ff[0] : lo_ff[0];
   assign vec[1] = cnt_ff[1] ? hi_ff[1] : lo_ff[1];
   assign vec[2] = cnt_ff[0] ? hi_ff[2] : lo_ff[2];
   assign seq_tag.valid = busy_ff;
   assign seq_tag.first = (cnt_ff == '0);
   assign seq_tag.last  = last_corner;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (en) begin
         if (accept && (req_mode == MODE_BOX)) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (last_corner) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_mode == MODE_BOX)) begin
         lo_ff[0] <= req_box_min_x;
         lo_ff[1] <= req_box_min_y;
         lo_ff[2] <= req_box_min_z;
         hi_ff[0] <= req_box_max_x;
         hi_ff[1] <= req_box_max_y;
         hi_ff[2] <= req_box_max_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_SIZE; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (accept && (req_mode == MODE_LOAD)) begin
         mat_ff[req_coef_index] <= req_coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_width_ff  <= VP_W'(1920);
         vp_height_ff <= VP_W'(1080);
         scale_ff     <= SCALE_ONE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VP_WIDTH:     vp_width_ff  <= csr_wdata[VP_W-1:0];
            CSR_VP_HEIGHT:    vp_height_ff <= csr_wdata[VP_W-1:0];
            CSR_BOUNDS_SCALE: scale_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   bsp_clip u_clip (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .mat     (mat_ff),
      .vec     (vec),
      .tag_in  (seq_tag),
      .tag_out (clip_tag),
      .clip_x  (clip_x),
      .clip_y  (clip_y),
      .clip_w  (clip_w)
   );

   bsp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .tag_in  (clip_tag),
      .clip_x  (clip_x),
      .clip_y  (clip_y),
      .clip_w  (clip_w),
      .tag_out (div_tag),
      .ok_out  (div_ok),
      .ndc_x   (ndc_x),
      .ndc_y   (ndc_y)
   );

   bsp_bounds u_bounds (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .tag_in    (div_tag),
      .ok_in     (div_ok),
      .ndc_x     (ndc_x),
      .ndc_y     (ndc_y),
      .vp_width  (vp_width_ff),
      .vp_height (vp_height_ff),
      .scale     (scale_ff),
      .res_valid (res_valid),
      .res_on    (res_on),
      .res_min_x (res_min_x),
      .res_min_y (res_min_y),
      .res_max_x (res_max_x),
      .res_max_y (res_max_y)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (en && res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && res_valid) begin
         on_ff    <= res_on;
         min_x_ff <= res_min_x;
         min_y_ff <= res_min_y;
         max_x_ff <= res_max_x;
         max_y_ff <= res_max_y;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_on_screen    = on_ff;
   assign rsp_screen_min_x = min_x_ff;
   assign rsp_screen_min_y = min_y_ff;
   assign rsp_screen_max_x = max_x_ff;
   assign rsp_screen_max_y = max_y_ff;

endmodule
`default_nettype wire

@@ rtl/core/bsp_clip.sv @@
// Clip-space transform of one corner: products, then floored sums with saturation.
`default_nettype none
module bsp_clip import bsp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic signed [QW-1:0] mat [MAT_SIZE],
   input  wire logic signed [QW-1:0] vec [3],
   input  wire tag_type              tag_in,
   output tag_type                   tag_out,
   output logic signed [QW-1:0]      clip_x,
   output logic signed [QW-1:0]      clip_y,
   output logic signed [QW-1:0]      clip_w
);

   localparam int PW   = 2 * QW;
   localparam int ACCW = PW - FRAC_BITS + 2;

   logic signed [PW-1:0] prod_ff [3][3];
   logic signed [QW-1:0] bias_ff [3];
   tag_type              tag1_ff;
   logic signed [QW-1:0] res_in [3];
   logic signed [QW-1:0] res_ff [3];
   tag_type              tag2_ff;

   // Only the x, y and w rows of the matrix are needed.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= PW'(mat[((r == 2) ? 3 : r) * 4 + k]) * PW'(vec[k]);
            end
            bias_ff[r] <= mat[((r == 2) ? 3 : r) * 4 + 3];
         end
      end
   end

   always_comb begin
      logic signed [ACCW-1:0] acc;
      for (int r = 0; r < 3; r++) begin
         acc = ACCW'(bias_ff[r]);
         for (int k = 0; k < 3; k++) begin
            acc = acc + ACCW'(prod_ff[r][k] >>> FRAC_BITS);
         end
         res_in[r] = sat_q(WIDE'(acc));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (en) begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   assign tag_out = tag2_ff;
   assign clip_x  = res_ff[0];
   assign clip_y  = res_ff[1];
   assign clip_w  = res_ff[2];

endmodule
`default_nettype wire

@@ rtl/core/bsp_div.sv @@
// Corner validity check and pipelined perspective divide of x and y by w.
`default_nettype none
module bsp_div import bsp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire tag_type                 tag_in,
   input  wire logic signed [QW-1:0]    clip_x,
   input  wire logic signed [QW-1:0]    clip_y,
   input  wire logic signed [QW-1:0]    clip_w,
   output tag_type                      tag_out,
   output logic                         ok_out,
   output logic signed [QBITS:0]        ndc_x,
   output logic signed [QBITS:0]        ndc_y
);

   localparam int NS = QBITS;

   div_lane_type        set_in  [2];
   div_lane_type        lane_in [1:NS][2];
   div_lane_type        lane_ff [NS+1][2];
   logic [QW-2:0]       den_ff  [NS+1];
   logic                ok_in;
   logic                ok_ff   [NS+1];
   tag_type             tag_ff  [NS+1];
   logic signed [QBITS:0] ndc_in [2];
   logic signed [QBITS:0] ndc_ff [2];
   logic                ok_o_ff;
   tag_type             tag_o_ff;

   // Set-up: corner is usable only if it lies in front and inside the frustum sides.
   always_comb begin
      logic signed [QW:0] xs;
      logic signed [QW:0] ys;
      logic signed [QW:0] ws;
      logic [QW-1:0]      mag;
      xs = (QW+1)'(clip_x);
      ys = (QW+1)'(clip_y);
      ws = (QW+1)'(clip_w);
      ok_in = (ws > '0) && (xs >= -ws) && (xs <= ws) && (ys >= -ws) && (ys <= ws);
      mag = clip_x[QW-1] ? QW'(-clip_x) : QW'(clip_x);
      set_in[0].neg = clip_x[QW-1];
      set_in[0].rem = {mag, FRAC_BITS'(0)};
      set_in[0].quo = '0;
      mag = clip_y[QW-1] ? QW'(-clip_y) : QW'(clip_y);
      set_in[1].neg = clip_y[QW-1];
      set_in[1].rem = {mag, FRAC_BITS'(0)};
      set_in[1].quo = '0;
   end

   // One quotient bit per stage, most significant first.
   always_comb begin
      logic [NUMW:0] trial;
      for (int s = 0; s < NS; s++) begin
         for (int l = 0; l < 2; l++) begin
            lane_in[s+1][l] = lane_ff[s][l];
            trial = {1'b0, lane_ff[s][l].rem} - ((NUMW+1)'(den_ff[s]) << (NS - 1 - s));
            if (!trial[NUMW]) begin
               lane_in[s+1][l].rem = trial[NUMW-1:0];
               lane_in[s+1][l].quo[NS-1-s] = 1'b1;
            end
         end
      end
   end

   // Floor of a negative quotient rounds the magnitude up when a remainder is left.
   always_comb begin
      logic signed [QBITS:0] q;
      for (int l = 0; l < 2; l++) begin
         q = {1'b0, lane_ff[NS][l].quo};
         if (lane_ff[NS][l].neg) begin
            ndc_in[l] = -q - (QBITS+1)'(lane_ff[NS][l].rem != '0);
         end else begin
            ndc_in[l] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff[0] <= set_in;
         den_ff[0]  <= clip_w[QW-2:0];
         ok_ff[0]   <= ok_in;
         for (int s = 0; s < NS; s++) begin
            lane_ff[s+1] <= lane_in[s+1];
            den_ff[s+1]  <= den_ff[s];
            ok_ff[s+1]   <= ok_ff[s];
         end
         ndc_ff  <= ndc_in;
         ok_o_ff <= ok_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NS; s++) begin
            tag_ff[s] <= '0;
         end
         tag_o_ff <= '0;
      end else if (en) begin
         tag_ff[0] <= tag_in;
         for (int s = 0; s < NS; s++) begin
            tag_ff[s+1] <= tag_ff[s];
         end
         tag_o_ff <= tag_ff[NS];
      end
   end

   assign tag_out = tag_o_ff;
   assign ok_out  = ok_o_ff;
   assign ndc_x   = ndc_ff[0];
   assign ndc_y   = ndc_ff[1];

endmodule
`default_nettype wire

@@ rtl/core/bsp_bounds.sv @@
// Pixel mapping, min/max over the eight corners and optional scaling about the centre.
`default_nettype none
module bsp_bounds import bsp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire tag_type               tag_in,
   input  wire logic                  ok_in,
   input  wire logic signed [QBITS:0] ndc_x,
   input  wire logic signed [QBITS:0] ndc_y,
   input  wire logic [VP_W-1:0]       vp_width,
   input  wire logic [VP_W-1:0]       vp_height,
   input  wire logic [SCALE_W-1:0]    scale,
   output logic                       res_valid,
   output logic                       res_on,
   output logic signed [QW-1:0]       res_min_x,
   output logic signed [QW-1:0]       res_min_y,
   output logic signed [QW-1:0]       res_max_x,
   output logic signed [QW-1:0]       res_max_y
);

   localparam int PXW = QBITS + 1 + VP_W;
   localparam int PRW = QW + SCALE_W;
   localparam logic [QBITS:0] ONE = (QBITS+1)'(1) << FRAC_BITS;

   logic signed [QW-1:0] sx_in, sy_in, sx_ff, sy_ff;
   tag_type              tagp_ff;
   logic                 okp_ff;
   logic signed [QW-1:0] mnx_in, mny_in, mxx_in, mxy_in;
   logic signed [QW-1:0] mnx_ff, mny_ff, mxx_ff, mxy_ff;
   logic                 bad_in, bad_ff;
   logic                 s1_valid_ff, s1_on_ff;
   logic signed [QW-1:0] s1_mnx_ff, s1_mny_ff, s1_mxx_ff, s1_mxy_ff;
   logic                 s2_valid_ff, s2_on_ff, s2_plain_ff;
   logic signed [QW-1:0] s2_mnx_ff, s2_mny_ff, s2_mxx_ff, s2_mxy_ff;
   logic signed [QW:0]   s2_cx_ff, s2_cy_ff;
   logic [PRW-1:0]       s2_px_ff, s2_py_ff;

   always_comb begin
      logic [QBITS:0] ax, ay;
      logic [PXW-1:0] px, py;
      ax = (QBITS+1)'(ndc_x) + ONE;
      ay = ONE - (QBITS+1)'(ndc_y);
      px = PXW'(ax) * PXW'(vp_width);
      py = PXW'(ay) * PXW'(vp_height);
      sx_in = sat_q(WIDE'(px >> 1));
      sy_in = sat_q(WIDE'(py >> 1));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         okp_ff <= ok_in;
      end
   end

   // Running bounds; the first corner of a box restarts them.
   always_comb begin
      if (tagp_ff.first) begin
         mnx_in = sx_ff;
         mxx_in = sx_ff;
         mny_in = sy_ff;
         mxy_in = sy_ff;
         bad_in = !okp_ff;
      end else begin
         mnx_in = (sx_ff < mnx_ff) ? sx_ff : mnx_ff;
         mxx_in = (sx_ff > mxx_ff) ? sx_ff : mxx_ff;
         mny_in = (sy_ff < mny_ff) ? sy_ff : mny_ff;
         mxy_in = (sy_ff > mxy_ff) ? sy_ff : mxy_ff;
         bad_in = bad_ff || !okp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && tagp_ff.valid) begin
         mnx_ff <= mnx_in;
         mxx_ff <= mxx_in;
         mny_ff <= mny_in;
         mxy_ff <= mxy_in;
         bad_ff <= bad_in;
      end
      if (en) begin
         s1_on_ff  <= !bad_in;
         s1_mnx_ff <= mnx_in;
         s1_mxx_ff <= mxx_in;
         s1_mny_ff <= mny_in;
         s1_mxy_ff <= mxy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_on_ff    <= s1_on_ff;
         s2_plain_ff <= (scale == SCALE_ONE);
         s2_mnx_ff   <= s1_mnx_ff;
         s2_mxx_ff   <= s1_mxx_ff;
         s2_mny_ff   <= s1_mny_ff;
         s2_mxy_ff   <= s1_mxy_ff;
         s2_cx_ff    <= ((QW+1)'(s1_mnx_ff) + (QW+1)'(s1_mxx_ff)) >>> 1;
         s2_cy_ff    <= ((QW+1)'(s1_mny_ff) + (QW+1)'(s1_mxy_ff)) >>> 1;
         s2_px_ff    <= PRW'(QW'(s1_mxx_ff - s1_mnx_ff)) * PRW'(scale);
         s2_py_ff    <= PRW'(QW'(s1_mxy_ff - s1_mny_ff)) * PRW'(scale);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tagp_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         tagp_ff     <= tag_in;
         s1_valid_ff <= tagp_ff.valid && tagp_ff.last;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_comb begin
      logic signed [WIDE-1:0] hx, hy, cx, cy;
      hx = $signed(WIDE'(s2_px_ff >> SCALE_SHIFT));
      hy = $signed(WIDE'(s2_py_ff >> SCALE_SHIFT));
      cx = WIDE'(s2_cx_ff);
      cy = WIDE'(s2_cy_ff);
      res_valid = s2_valid_ff;
      res_on    = s2_on_ff;
      if (!s2_on_ff) begin
         res_min_x = '0;
         res_min_y = '0;
         res_max_x = '0;
         res_max_y = '0;
      end else if (s2_plain_ff) begin
         res_min_x = s2_mnx_ff;
         res_min_y = s2_mny_ff;
         res_max_x = s2_mxx_ff;
         res_max_y = s2_mxy_ff;
      end else begin
         res_min_x = sat_q(cx - hx);
         res_max_x = sat_q(cx + hx);
         res_min_y = sat_q(cy - hy);
         res_max_y = sat_q(cy + hy);
      end
   end

endmodule
`default_nettype wire

@@ test/tb_box_screen_bounds_projector.sv @@
// Self-checking testbench for the box screen-bounds projector.
`timescale 1ns / 100ps
module tb_box_screen_bounds_projector;
   import bsp_pkg::*;

   typedef struct {
      logic             on_screen;
      logic signed [31:0] min_x, min_y, max_x, max_y;
   } bounds_type;

   typedef struct {
      mode_type           mode;
      logic [3:0]         idx;
      logic signed [31:0] coef;
      logic signed [31:0] lo [3];
      logic signed [31:0] hi [3];
   } item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = 1'b0;
   logic [3:0] req_coef_index = '0;
   logic signed [31:0] req_coef_value = '0;
   logic signed [31:0] req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   logic signed [31:0] req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_on_screen;
   logic signed [31:0] rsp_screen_min_x, rsp_screen_min_y, rsp_screen_max_x, rsp_screen_max_y;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SCALE_W-1:0] csr_wdata = '0;

   logic signed [31:0] matrix [16];
   longint vp_width, vp_height, scale;
   bounds_type pending_bounds [$];
   int errors = 0;
   int boxes_sent = 0, loads_sent = 0, bounds_seen = 0, visible_seen = 0;
   bit idle_enable = 1'b1;
   int hold_cycles = 0;

   box_screen_bounds_projector u_top (.*);

   always #10 clock = ~clock;

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Works out the screen bounds of a box under the current matrix, viewport and scale.
   function automatic bounds_type project_box(item_type it);
      bounds_type b;
      longint one, v[3], res[3], acc, w, nx, ny, sx, sy, cx, cy, hx, hy;
      longint mnx, mny, mxx, mxy;
      int rows[3];
      rows = '{0, 1, 3};
      one = 64'sd1 << FRAC_BITS;
      b = '{1'b0, 0, 0, 0, 0};
      mnx = 0; mny = 0; mxx = 0; mxy = 0;
      for (int c = 0; c < 8; c++) begin
         v[0] = (c & 4) ? it.hi[0] : it.lo[0];
         v[1] = (c & 2) ? it.hi[1] : it.lo[1];
         v[2] = (c & 1) ? it.hi[2] : it.lo[2];
         for (int r = 0; r < 3; r++) begin
            acc = matrix[rows[r]*4+3];
            for (int k = 0; k < 3; k++) acc += floor_div(longint'(matrix[rows[r]*4+k]) * v[k], one);
            res[r] = sat32(acc);
         end
         w = res[2];
         if (w <= 0 || res[0] < -w || res[0] > w || res[1] < -w || res[1] > w) return b;
         nx = floor_div(res[0] * one, w);
         ny = floor_div(res[1] * one, w);
         sx = sat32(floor_div((nx + one) * vp_width, 2));
         sy = sat32(floor_div((one - ny) * vp_height, 2));
         if (c == 0) begin
            mnx = sx; mxx = sx; mny = sy; mxy = sy;
         end else begin
            if (sx < mnx) mnx = sx;
            if (sx > mxx) mxx = sx;
            if (sy < mny) mny = sy;
            if (sy > mxy) mxy = sy;
         end
      end
      if (scale != 65536) begin
         cx = floor_div(mnx + mxx, 2);
         cy = floor_div(mny + mxy, 2);
         hx = floor_div((mxx - mnx) * scale, 64'sd1 << SCALE_SHIFT);
         hy = floor_div((mxy - mny) * scale, 64'sd1 << SCALE_SHIFT);
         mnx = sat32(cx - hx); mxx = sat32(cx + hx);
         mny = sat32(cy - hy); mxy = sat32(cy + hy);
      end
      b = '{1'b1, mnx, mny, mxx, mxy};
      return b;
   endfunction

   // Leaves the request valid after acceptance; the next idle cycle or a pause drops it.
   task automatic send_item(item_type it);
      while (idle_enable && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_coef_index <= it.idx;
      req_coef_value <= it.coef;
      req_box_min_x <= it.lo[0]; req_box_min_y <= it.lo[1]; req_box_min_z <= it.lo[2];
      req_box_max_x <= it.hi[0]; req_box_max_y <= it.hi[1]; req_box_max_z <= it.hi[2];
      do @(posedge clock); while (!req_ready);
      if (it.mode == MODE_LOAD) begin
         matrix[it.idx] = it.coef;
         loads_sent++;
      end else begin
         pending_bounds.push_back(project_box(it));
         boxes_sent++;
      end
      @(negedge clock);
   endtask

   task automatic load_coef(int idx, logic signed [31:0] value);
      item_type it;
      it.mode = MODE_LOAD; it.idx = 4'(idx); it.coef = value;
      it.lo = '{$urandom, $urandom, $urandom};
      it.hi = '{$urandom, $urandom, $urandom};
      send_item(it);
   endtask

   task automatic send_box(logic signed [31:0] x0, y0, z0, x1, y1, z1);
      item_type it;
      it.mode = MODE_BOX; it.idx = 4'($urandom); it.coef = $urandom;
      it.lo = '{x0, y0, z0};
      it.hi = '{x1, y1, z1};
      send_item(it);
   endtask

   // Orthographic-like matrix with w fixed at one; boxes in [-1,1] land on screen.
   task automatic load_plain_matrix(logic signed [31:0] sx, logic signed [31:0] sy);
      for (int i = 0; i < 16; i++) load_coef(i, 0);
      load_coef(0, sx);
      load_coef(5, sy);
      load_coef(15, 32'sh10000);
   endtask

   task automatic write_csr(csr_index_type idx, logic [SCALE_W-1:0] value);
      req_valid <= 1'b0;
      wait (pending_bounds.size() == 0);
      repeat (40) @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_VP_WIDTH:     vp_width = value[15:0];
         CSR_VP_HEIGHT:    vp_height = value[15:0];
         CSR_BOUNDS_SCALE: scale = value;
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] small_coord();
      return $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
   endfunction

   task automatic send_random_box();
      if ($urandom_range(99) < 80)
         send_box(small_coord(), small_coord(), small_coord(),
                  small_coord(), small_coord(), small_coord());
      else
         send_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_reset_matrix();
      // With the matrix still zero, w is zero and every box is off screen.
      send_box(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000);
   endtask

   task automatic test_directed_boxes();
      load_plain_matrix(32'sh10000, 32'sh10000);
      send_box(-32'sh10000, -32'sh10000, 0, 32'sh10000, 32'sh10000, 0);
      send_box(32'sh8000, 32'sh8000, 32'sh10000, -32'sh8000, -32'sh4000, -32'sh10000);
      send_box(0, 0, 0, 32'sh10001, 0, 0);
      send_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
               32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
      send_box(32'sh1234, -32'sh4321, 32'sh7fffffff, 32'sh1234, -32'sh4321, 32'sh80000000);
      load_coef(15, -32'sh10000);
      send_box(0, 0, 0, 0, 0, 0);
      load_coef(15, 32'sh7fffffff);
      load_coef(0, 32'sh80000000);
      send_box(32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0);
   endtask

   task automatic test_viewport_settings();
      load_plain_matrix(32'sh8000, 32'sh8000);
      load_coef(14, 32'sh4000);
      load_coef(15, 32'sh10000);
      write_csr(CSR_VP_WIDTH, 0);
      write_csr(CSR_VP_HEIGHT, 0);
      repeat (4) send_random_box();
      write_csr(CSR_VP_WIDTH, 16'hffff);
      write_csr(CSR_VP_HEIGHT, 16'hffff);
      repeat (4) send_random_box();
      write_csr(CSR_VP_WIDTH, 1);
      write_csr(CSR_VP_HEIGHT, 1);
      repeat (4) send_random_box();
   endtask

   task automatic test_scales();
      logic [SCALE_W-1:0] scales [5];
      scales = '{0, 21'h100000, 21'h1fffff, 21'h8000, 65536};
      write_csr(CSR_VP_WIDTH, 1920);
      write_csr(CSR_VP_HEIGHT, 1080);
      foreach (scales[i]) begin
         write_csr(CSR_BOUNDS_SCALE, scales[i]);
         repeat (5) send_random_box();
      end
   endtask

   task automatic test_random_traffic();
      for (int n = 0; n < 800; n++) begin
         if (n == 300) idle_enable = 1'b0;
         if (n == 400) idle_enable = 1'b1;
         if (n == 500) hold_cycles = 300;
         if (n % 200 == 199) begin
            write_csr(CSR_VP_WIDTH, SCALE_W'($urandom_range(1, 65535)));
            write_csr(CSR_VP_HEIGHT, SCALE_W'($urandom_range(1, 65535)));
            write_csr(CSR_BOUNDS_SCALE, SCALE_W'($urandom_range(0, 21'h1fffff)));
         end
         if ($urandom_range(99) < 20) begin
            if ($urandom_range(99) < 70) load_coef($urandom_range(0, 15),
                                                   $signed($urandom_range(0, 32'h30000)) - 32'sh18000);
            else load_coef($urandom_range(0, 15), $urandom);
         end else begin
            send_random_box();
         end
      end
   endtask

   // Receiver: random stalls, plus a long hold-off when requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_enable && $urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      bounds_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bounds_seen++;
         if (rsp_on_screen) visible_seen++;
         if (pending_bounds.size() == 0) begin
            $error("unexpected bounds transaction");
            errors++;
         end else begin
            want = pending_bounds.pop_front();
            if (rsp_on_screen !== want.on_screen) begin
               $error("on_screen expected %0d got %0d", want.on_screen, rsp_on_screen); errors++;
            end
            if (rsp_screen_min_x !== want.min_x) begin
               $error("screen_min_x expected %0d got %0d", want.min_x, rsp_screen_min_x); errors++;
            end
            if (rsp_screen_min_y !== want.min_y) begin
               $error("screen_min_y expected %0d got %0d", want.min_y, rsp_screen_min_y); errors++;
            end
            if (rsp_screen_max_x !== want.max_x) begin
               $error("screen_max_x expected %0d got %0d", want.max_x, rsp_screen_max_x); errors++;
            end
            if (rsp_screen_max_y !== want.max_y) begin
               $error("screen_max_y expected %0d got %0d", want.max_y, rsp_screen_max_y); errors++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      foreach (matrix[i]) matrix[i] = 0;
      vp_width = 1920; vp_height = 1080; scale = 65536;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_matrix();
      test_directed_boxes();
      test_viewport_settings();
      test_scales();
      test_random_traffic();
      req_valid <= 1'b0;
      wait (pending_bounds.size() == 0);
      repeat (60) @(posedge clock);
      $display("Sent %0d boxes and %0d coefficient loads; checked %0d bounds, %0d on screen.",
               boxes_sent, loads_sent, bounds_seen, visible_seen);
      if (errors == 0 && pending_bounds.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
